[rtl/tmp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package tmp_pkg;
  localparam int unsigned PosW = 48;
  localparam int unsigned SpdW = 33;
  localparam int unsigned DivW = 64;
  localparam logic [2:0] ACT_TICK = 3'd0;
  localparam logic [2:0] ACT_GOTO = 3'd1;
  localparam logic [2:0] ACT_DGOTO = 3'd2;
  localparam logic [2:0] ACT_STOP = 3'd3;
  localparam logic [2:0] ACT_SETTGT = 3'd4;
  localparam logic [2:0] ACT_RESET = 3'd5;
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_REQ = 3'd1;
  localparam logic [2:0] PH_ACCEL = 3'd2;
  localparam logic [2:0] PH_BRAKE = 3'd3;
  localparam logic [2:0] PH_REACHED = 3'd4;
  localparam logic [1:0] ADDR_ACCEL = 2'd0;
  localparam logic [1:0] ADDR_LIMIT = 2'd1;
  localparam logic [1:0] ADDR_DELAY = 2'd2;

  typedef struct packed {
    logic start;       // latch inputs, run pre-step
    logic div_start;   // start brake distance divide
    logic finish;      // apply post-step
  } tmp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } tmp_sts_t;
endpackage
`default_nettype wire

[rtl/tmp_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module tmp_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output tmp_pkg::tmp_cmd_t  cmd_o,
  input  tmp_pkg::tmp_sts_t  sts_i
);
  typedef enum logic [2:0] {S_IDLE, S_PRE, S_DIV, S_WAIT, S_POST, S_OUT} state_e;
  state_e state_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  always_comb begin
    cmd_o.start     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.div_start = (state_q == S_DIV);
    cmd_o.finish    = (state_q == S_POST);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_PRE;
        S_PRE: state_q <= sts_i.need_div ? S_DIV : S_POST;
        S_DIV: state_q <= S_WAIT;
        S_WAIT: if (sts_i.div_done) state_q <= S_POST;
        S_POST: state_q <= S_OUT;
        S_OUT: if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/tmp_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module tmp_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] num_i,
  input  wire logic [31:0] den_i,
  output logic             done_o,
  output logic [63:0]      quo_o
);
  logic [63:0] quo_q;
  logic [32:0] rem_q;
  logic [31:0] den_q;
  logic [6:0]  cnt_q;
  logic        busy_q;
  logic [32:0] sh;
  logic        ge;

  assign sh = {rem_q[31:0], quo_q[63]};
  assign ge = (sh >= {1'b0, den_q});
  assign quo_o = quo_q;
  assign done_o = !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 7'd64;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? sh - {1'b0, den_q} : sh;
      quo_q <= {quo_q[62:0], ge};
    end
  end
endmodule
`default_nettype wire

[rtl/tmp_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module tmp_dp (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  tmp_pkg::tmp_cmd_t cmd_i,
  output tmp_pkg::tmp_sts_t sts_o,
  input  wire logic [2:0]   action_i,
  input  wire logic signed [47:0] meas_i,
  input  wire logic signed [47:0] target_i,
  input  wire logic [31:0]  cruise_i,
  input  wire logic [15:0]  delay_i,
  input  wire logic [31:0]  max_accel_i,
  input  wire logic [46:0]  limit_i,
  input  wire logic [15:0]  def_delay_i,
  output logic signed [47:0] setpoint_o,
  output logic signed [32:0] speed_o,
  output logic [2:0]        phase_o,
  output logic              cruising_o,
  output logic              fault_o
);
  localparam logic signed [49:0] PMAX = 50'sd140737488355327;
  localparam logic signed [49:0] PMIN = -50'sd140737488355328;
  localparam logic signed [33:0] SMAX = 34'sd4294967295;
  localparam logic signed [33:0] SMIN = -34'sd4294967296;

  logic [2:0] act_q, phase_q;
  logic signed [47:0] meas_q, tgt_q, setp_q, goal_q;
  logic [31:0] cru_in_q, cru_lim_q;
  logic [15:0] dly_in_q, dcnt_q;
  logic signed [32:0] spd_q, sacc_q, scru_q;
  logic fwd_q, cru_q, fault_q;
  logic pre_q;
  logic [63:0] sq_q;
  logic div_done;
  logic [63:0] quo;
  logic [31:0] den;

  // pre-step combinational results
  logic signed [33:0] v_sum, v_new;
  logic [32:0] v_abs, c_abs;
  logic clamp;
  logic signed [49:0] p_sum, p_new;
  logic signed [32:0] spd_pre;
  logic signed [47:0] setp_pre;

  always_comb begin
    v_sum = 34'(spd_q) + 34'(sacc_q);
    if (phase_q == tmp_pkg::PH_BRAKE) v_sum = 34'(spd_q) - 34'(sacc_q);
    v_abs = v_sum[33] ? 33'(-v_sum) : 33'(v_sum);
    c_abs = scru_q[32] ? 33'(-34'(scru_q)) : 33'(scru_q);
    clamp = (phase_q == tmp_pkg::PH_ACCEL) && (v_abs > c_abs);
    v_new = clamp ? 34'(scru_q) : v_sum;
    if (v_new > SMAX) v_new = SMAX;
    else if (v_new < SMIN) v_new = SMIN;
    spd_pre = 33'(v_new);
    p_sum = 50'(setp_q) + 50'(spd_pre);
    p_new = (p_sum > PMAX) ? PMAX : ((p_sum < PMIN) ? PMIN : p_sum);
    setp_pre = 48'(p_new);
  end

  logic [47:0] gap;
  logic signed [48:0] gdiff;
  assign gdiff = 49'(meas_q) - 49'(setp_q);
  assign gap = gdiff[48] ? 48'(-gdiff) : 48'(gdiff);

  logic is_move;
  assign is_move = (act_q == tmp_pkg::ACT_TICK) && (phase_q == tmp_pkg::PH_ACCEL);

  // squared speed magnitude, saturated once it no longer fits 32 bits
  logic [32:0] spre_abs, spd_abs;
  logic [63:0] sq_prod, sq_d;
  assign spre_abs = spd_pre[32] ? 33'(-34'(spd_pre)) : 33'(spd_pre);
  assign spd_abs = is_move ? spre_abs : (spd_q[32] ? 33'(-34'(spd_q)) : 33'(spd_q));
  assign sq_prod = {32'd0, spd_abs[31:0]} * {32'd0, spd_abs[31:0]};
  assign sq_d = spd_abs[32] ? '1 : sq_prod;

  always_comb begin
    sts_o.need_div = (sacc_q != '0) && ((act_q == tmp_pkg::ACT_STOP) || is_move);
    sts_o.div_done = div_done;
  end

  assign den = sacc_q[32] ? 32'(-sacc_q) : 32'(sacc_q);

  tmp_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i({1'b0, sq_q[63:1]}),
    .den_i(den), .done_o(div_done), .quo_o(quo)
  );

  // brake distance signed, with divider result (zero when accel zero)
  logic signed [64:0] bd;
  logic signed [64:0] diff65, gsum;
  logic signed [63:0] diff;
  logic signed [49:0] gnew;
  logic go_brake;
  always_comb begin
    bd = (sacc_q == '0) ? '0 : (sacc_q[32] ? -65'({1'b0, quo}) : 65'({1'b0, quo}));
    diff65 = 65'(goal_q) - 65'(setp_q);
    diff = 64'(diff65);
    go_brake = fwd_q ? (65'(diff) < bd) : (65'(diff) > bd);
    gsum = 65'(setp_q) + bd;
    gnew = (gsum > 65'(PMAX)) ? PMAX : ((gsum < 65'(PMIN)) ? PMIN : 50'(gsum));
  end

  assign setpoint_o = setp_q;
  assign speed_o = spd_q;
  assign phase_o = phase_q;
  assign cruising_o = cru_q;
  assign fault_o = fault_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      act_q <= action_i; meas_q <= meas_i; tgt_q <= target_i;
      cru_in_q <= cruise_i; dly_in_q <= delay_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tmp_pkg::PH_IDLE; setp_q <= '0; goal_q <= '0; spd_q <= '0;
      cru_lim_q <= '0; sacc_q <= '0; scru_q <= '0; fwd_q <= 1'b0;
      dcnt_q <= '0; cru_q <= 1'b0; fault_q <= 1'b0; sq_q <= '0;
    end else if (pre_q) begin
      // fault test on the old setpoint; accel step here so brake distance sees new speed
      sq_q <= sq_d;
      if ((act_q == tmp_pkg::ACT_TICK) && (gap >= {1'b0, limit_i})) fault_q <= 1'b1;
      if (is_move) begin
        spd_q <= spd_pre; setp_q <= setp_pre;
        if (clamp) cru_q <= 1'b1;
      end
    end else if (cmd_i.finish) begin
      case (act_q)
        tmp_pkg::ACT_GOTO, tmp_pkg::ACT_DGOTO: begin
          goal_q <= tgt_q; cru_lim_q <= cru_in_q; phase_q <= tmp_pkg::PH_REQ;
          dcnt_q <= (act_q == tmp_pkg::ACT_GOTO) ? 16'd0 :
                    ((dly_in_q != 16'd0) ? dly_in_q : def_delay_i);
        end
        tmp_pkg::ACT_STOP: goal_q <= 48'(gnew);
        tmp_pkg::ACT_SETTGT: goal_q <= tgt_q;
        tmp_pkg::ACT_RESET: begin
          phase_q <= tmp_pkg::PH_IDLE; fault_q <= 1'b0; spd_q <= '0; setp_q <= meas_q;
        end
        tmp_pkg::ACT_TICK: begin
          case (phase_q)
            tmp_pkg::PH_IDLE: cru_q <= 1'b0;
            tmp_pkg::PH_REQ: begin
              fwd_q <= goal_q >= meas_q;
              sacc_q <= (goal_q >= meas_q) ? 33'(max_accel_i) : -33'(max_accel_i);
              scru_q <= (goal_q >= meas_q) ? 33'(cru_lim_q) : -33'(cru_lim_q);
              if (dcnt_q != 16'd0) dcnt_q <= dcnt_q - 16'd1;
              else begin spd_q <= '0; phase_q <= tmp_pkg::PH_ACCEL; end
            end
            tmp_pkg::PH_ACCEL: begin
              if (go_brake) phase_q <= tmp_pkg::PH_BRAKE;
            end
            tmp_pkg::PH_BRAKE: begin
              spd_q <= spd_pre; setp_q <= setp_pre; cru_q <= 1'b0;
              if (fwd_q ? (spd_pre <= 0) : (spd_pre >= 0)) phase_q <= tmp_pkg::PH_REACHED;
            end
            default: begin setp_q <= goal_q; phase_q <= tmp_pkg::PH_IDLE; end
          endcase
        end
        default: ;
      endcase
    end
  end

  // one-shot marker for the cycle after start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pre_q <= 1'b0;
    else pre_q <= cmd_i.start;
  end
endmodule
`default_nettype wire

[rtl/trapezoidal_motion_profile_top.sv]
// Channel  | Handshake                 | Beat
// input    | in_valid_i / in_ready_o   | action, positions, cruise speed, delay
// output   | out_valid_o / out_ready_i | setpoint, speed, phase, flags
// config   | APB psel/penable/pwrite   | max_accel, following_limit, default_delay
// A beat that needs the braking distance (accelerating tick or stop with nonzero accel)
// also waits for a 64-step radix-2 divider before its result beat is offered.
// The next input beat is taken once the result beat has been accepted.
// Reset is asynchronous and active low; the input latches and divider data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module trapezoidal_motion_profile_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  action_i,
  input  wire logic signed [47:0] measured_position_i,
  input  wire logic signed [47:0] target_position_i,
  input  wire logic [31:0] cruise_speed_i,
  input  wire logic [15:0] delay_ticks_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic signed [47:0] commanded_position_o,
  output logic signed [32:0] profile_speed_o,
  output logic [2:0]       phase_o,
  output logic             speed_reached_o,
  output logic             track_fault_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  logic [31:0] accel_q;
  logic [46:0] limit_q;
  logic [15:0] ddly_q;
  tmp_pkg::tmp_cmd_t cmd;
  tmp_pkg::tmp_sts_t sts;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q <= 32'd429497; limit_q <= 47'h1_0000_0000; ddly_q <= 16'd500;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:3])
        tmp_pkg::ADDR_ACCEL: accel_q <= pwdata[31:0];
        tmp_pkg::ADDR_LIMIT: limit_q <= pwdata[46:0];
        tmp_pkg::ADDR_DELAY: ddly_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[4:3])
      tmp_pkg::ADDR_ACCEL: prdata = 64'(accel_q);
      tmp_pkg::ADDR_LIMIT: prdata = 64'(limit_q);
      tmp_pkg::ADDR_DELAY: prdata = 64'(ddly_q);
      default: prdata = '0;
    endcase
  end

  tmp_ctrl u_ctrl (.clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .sts_i(sts));
  tmp_dp u_dp (.clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .action_i,
    .meas_i(measured_position_i), .target_i(target_position_i), .cruise_i(cruise_speed_i),
    .delay_i(delay_ticks_i), .max_accel_i(accel_q), .limit_i(limit_q), .def_delay_i(ddly_q),
    .setpoint_o(commanded_position_o), .speed_o(profile_speed_o), .phase_o,
    .cruising_o(speed_reached_o), .fault_o(track_fault_o));
endmodule
`default_nettype wire
